// ----- hdl/cde_pkg.sv -----
// Shared types and codes for the circular deque engine.
`default_nettype none

package cde_pkg;

   localparam int WORD_W   = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // request beat layout
   localparam int REQ_DATA_W = 40;
   // response beat layout
   localparam int RSP_DATA_W = 80;

   // action codes carried in a request
   localparam logic [ACTION_W-1:0] ACT_ADD_FRONT  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_BACK   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_TAKE_FRONT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_TAKE_BACK  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REVERSE    = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SORT       = 3'd6;

   // status codes carried in a response
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;

   // per-cycle command broadcast to every cell
   localparam int CELL_OP_W = 3;
   localparam logic [CELL_OP_W-1:0] CELL_HOLD       = 3'd0;
   localparam logic [CELL_OP_W-1:0] CELL_ADD_FRONT  = 3'd1;
   localparam logic [CELL_OP_W-1:0] CELL_ADD_BACK   = 3'd2;
   localparam logic [CELL_OP_W-1:0] CELL_TAKE_FRONT = 3'd3;
   localparam logic [CELL_OP_W-1:0] CELL_TAKE_BACK  = 3'd4;
   localparam logic [CELL_OP_W-1:0] CELL_CLEAR      = 3'd5;
   localparam logic [CELL_OP_W-1:0] CELL_REVERSE    = 3'd6;
   localparam logic [CELL_OP_W-1:0] CELL_SORT       = 3'd7;

   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

   typedef struct packed {
      logic [CELL_OP_W-1:0]      op;
      logic                      parity;  // sort phase: pairs start on even or odd cells
      logic signed [WORD_W-1:0]  value;   // word being pushed
   } cell_ctl_type;

   // what a cell shows its neighbors: a is the front-ordered copy, b the back-ordered one
   typedef struct packed {
      logic                      valid;
      logic signed [WORD_W-1:0]  a;
      logic signed [WORD_W-1:0]  b;
   } cell_link_type;

endpackage

`default_nettype wire

// ----- hdl/cde_cell.sv -----
// One deque cell: a word of the front-ordered chain and of the back-ordered chain.
`default_nettype none

module cde_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   idx_odd,
   input  logic                   is_head,
   input  cde_pkg::cell_ctl_type  ctl,
   input  cde_pkg::cell_link_type left_link,
   input  cde_pkg::cell_link_type right_link,
   output cde_pkg::cell_link_type link
);
   import cde_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [WORD_W-1:0] a_ff, a_in;
   logic signed [WORD_W-1:0] b_ff, b_in;

   always_comb begin
      valid_in = valid_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      case (ctl.op)
         CELL_ADD_FRONT: begin
            valid_in = left_link.valid;
            a_in     = left_link.a;
            if (!valid_ff && left_link.valid) begin
               b_in = ctl.value;
            end
         end
         CELL_ADD_BACK: begin
            valid_in = left_link.valid;
            b_in     = left_link.b;
            if (!valid_ff && left_link.valid) begin
               a_in = ctl.value;
            end
         end
         CELL_TAKE_FRONT: begin
            valid_in = right_link.valid;
            a_in     = right_link.a;
         end
         CELL_TAKE_BACK: begin
            valid_in = right_link.valid;
            b_in     = right_link.b;
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         CELL_REVERSE: begin
            a_in = b_ff;
            b_in = a_ff;
         end
         CELL_SORT: begin
            // odd-even transposition: a ascends, b descends
            if (idx_odd == ctl.parity) begin
               if (right_link.valid) begin
                  if (right_link.a < a_ff) a_in = right_link.a;
                  if (right_link.b > b_ff) b_in = right_link.b;
               end
            end else if (!is_head && valid_ff) begin
               if (left_link.a > a_ff) a_in = left_link.a;
               if (left_link.b < b_ff) b_in = left_link.b;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign link = '{valid: valid_ff, a: a_ff, b: b_ff};

endmodule

`default_nettype wire

// ----- hdl/circular_deque_engine_core.sv -----
// Top level of the circular deque engine: control, cell chain and response register.
`default_nettype none

// Double-ended queue of signed 32-bit words, up to DEPTH deep. Every request
// beat carries one action (push front/back, pop front/back, clear, reverse,
// sort ascending) and produces exactly one response beat with the status
// (ok, overflow, underflow), the front and back words (-1 when empty), the
// count and the empty/full flags. Storage is a row of DEPTH cells; each
// cell holds the word at its place counted from the front and, in a second
// chain, the word at its place counted from the back, so both ends sit in
// cell 0 and every push or pop is a one-step shift or append between
// neighbors. Pushes, pops, clear, reverse and the unused code sustain one
// beat per cycle while rsp_tready keeps the response register free; the
// new cell state is registered first and then loaded into the response
// register. Sort of n >= 2 words runs n odd-even transposition phases over
// the cell row and holds the request side until they are done. The response
// register lets the next request in while an earlier response still waits on rsp_tready.
module circular_deque_engine_core #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: [2:0] action, [34:3] value, [39:35] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cde_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response: [1:0] status, [33:2] front_value, [65:34] back_value,
   //           [72:66] count, [73] is_empty, [74] is_full, [79:75] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cde_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import cde_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // request fields
   logic [ACTION_W-1:0]      req_action;
   logic signed [WORD_W-1:0] req_value;
   assign req_action = req_tdata[ACTION_W-1:0];
   assign req_value  = req_tdata[ACTION_W +: WORD_W];

   // control state
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                sort_ff, sort_in;
   logic [CNT_W-1:0]    phase_ff, phase_in;
   logic                pend_ff, pend_in;     // cells hold a state not yet reported
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // response payload
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic signed [WORD_W-1:0] rsp_front_ff;
   logic signed [WORD_W-1:0] rsp_back_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_empty_ff;
   logic                     rsp_full_ff;

   logic         accept;
   logic         load;
   logic         start_sort;
   logic         sort_done;
   logic         is_empty;
   logic         is_full;
   cell_ctl_type ctl;

   cell_link_type cell_link [DEPTH];
   logic [DEPTH-1:0] valid_vec;

   assign is_empty = !valid_vec[0];
   assign is_full  = valid_vec[DEPTH-1];

   // a waiting state moves into the response register when it is free
   assign load       = pend_ff && (!rsp_tvalid_ff || rsp_tready);
   assign req_tready = !sort_ff && (!pend_ff || load);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      ctl        = '{op: CELL_HOLD, parity: phase_ff[0], value: req_value};
      count_in   = count_ff;
      status_in  = status_ff;
      start_sort = 1'b0;
      sort_done  = 1'b0;
      sort_in    = sort_ff;
      phase_in   = phase_ff;
      if (sort_ff) begin
         ctl.op   = CELL_SORT;
         phase_in = phase_ff + 1'b1;
         if (phase_ff == count_ff - 1'b1) begin
            sort_in   = 1'b0;
            sort_done = 1'b1;
         end
      end else if (accept) begin
         status_in = STS_OK;
         case (req_action)
            ACT_ADD_FRONT, ACT_ADD_BACK: begin
               if (is_full) begin
                  status_in = STS_OVERFLOW;
               end else begin
                  ctl.op   = (req_action == ACT_ADD_FRONT) ? CELL_ADD_FRONT : CELL_ADD_BACK;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_TAKE_FRONT, ACT_TAKE_BACK: begin
               if (is_empty) begin
                  status_in = STS_UNDERFLOW;
               end else begin
                  ctl.op   = (req_action == ACT_TAKE_FRONT) ? CELL_TAKE_FRONT : CELL_TAKE_BACK;
                  count_in = count_ff - 1'b1;
               end
            end
            ACT_CLEAR: begin
               ctl.op   = CELL_CLEAR;
               count_in = '0;
            end
            ACT_REVERSE: begin
               // the two chains simply trade places
               ctl.op = CELL_REVERSE;
            end
            ACT_SORT: begin
               if (count_ff > CNT_W'(1)) begin
                  start_sort = 1'b1;
                  sort_in    = 1'b1;
                  phase_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign pend_in       = (accept && !start_sort) || sort_done || (pend_ff && !load);
   assign rsp_tvalid_in = load || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sort_ff       <= 1'b0;
         phase_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sort_ff       <= sort_in;
         phase_ff      <= phase_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (load) begin
         rsp_status_ff <= status_ff;
         rsp_front_ff  <= is_empty ? EMPTY_WORD : cell_link[0].a;
         rsp_back_ff   <= is_empty ? EMPTY_WORD : cell_link[0].b;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_empty_ff  <= is_empty;
         rsp_full_ff   <= is_full;
      end
   end

   // cell row: cell 0 sees the incoming word on its left, the last cell an empty right
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;

      if (i == 0) begin : g_head
         assign left_link = '{valid: 1'b1, a: req_value, b: req_value};
      end else begin : g_mid_left
         assign left_link = cell_link[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_link = '{valid: 1'b0, a: '0, b: '0};
      end else begin : g_mid_right
         assign right_link = cell_link[i+1];
      end

      cde_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .idx_odd    (1'(i % 2)),
         .is_head    (i == 0),
         .ctl        (ctl),
         .left_link  (left_link),
         .right_link (right_link),
         .link       (cell_link[i])
      );

      assign valid_vec[i] = cell_link[i].valid;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, rsp_full_ff, rsp_empty_ff, rsp_count_ff,
                        rsp_back_ff, rsp_front_ff, rsp_status_ff};

   // occupied cells always form a run starting at cell 0
   assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & (valid_vec + 1'b1)) == '0))
      else $error("occupied cells are not packed toward the front");

   // the count register tracks the occupied run
   assert property (@(posedge clock) disable iff (reset)
      ($countones(valid_vec) == int'(count_ff)))
      else $error("count disagrees with occupied cells");

   // no request is taken while a sort walks the cells
   assert property (@(posedge clock) disable iff (reset)
      sort_ff |-> !req_tready)
      else $error("request accepted during sort");

   // a sort never overlaps an unreported state
   assert property (@(posedge clock) disable iff (reset)
      !(sort_ff && pend_ff))
      else $error("sort running with a pending report");

   // sort phases stay below the word count
   assert property (@(posedge clock) disable iff (reset)
      sort_ff |-> (phase_ff < count_ff))
      else $error("sort phase past count");

endmodule

`default_nettype wire

// ----- tb/sv/circular_deque_engine_core_tb.sv -----
// Self-checking testbench for the circular deque engine: directed edges, fill/overflow, random traffic.
module circular_deque_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cde_pkg::*;

   localparam int DEPTH = 64;
   // action code with no meaning; the block must answer ok and change nothing
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
   localparam int PAD_W = RSP_DATA_W - 75;

   // expected response beat, laid out exactly as rsp_tdata[74:0]
   typedef struct packed {
      logic                      is_full;
      logic                      is_empty;
      logic [COUNT_W-1:0]        count;
      logic signed [WORD_W-1:0]  back_value;
      logic signed [WORD_W-1:0]  front_value;
      logic [STATUS_W-1:0]       status;
   } deque_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   // shadow of the stored words, front at index 0
   int            shadow_words[$];
   deque_rsp_type pending_rsp[$];

   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold_left = 0;

   int err_count    = 0;
   int beats_sent   = 0;
   int beats_seen   = 0;
   int n_overflow   = 0;
   int n_underflow  = 0;
   int n_sorts      = 0;
   int peak_count   = 0;

   deque_rsp_type want_rsp;
   deque_rsp_type got_rsp;

   circular_deque_engine_core #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: applies one action to the shadow deque, returns the beat.
   // ---------------------------------------------------------------------
   function automatic deque_rsp_type apply_action(input logic [ACTION_W-1:0] action,
                                                  input logic signed [WORD_W-1:0] value);
      deque_rsp_type r;
      int n;
      int i;
      int j;
      int key;
      int tmp;
      r = '0;
      r.status = STS_OK;
      n = shadow_words.size();
      case (action)
         ACT_ADD_FRONT, ACT_ADD_BACK: begin
            if (n >= DEPTH) begin
               r.status = STS_OVERFLOW;
            end else if (action == ACT_ADD_FRONT) begin
               shadow_words.insert(0, value);
            end else begin
               shadow_words.insert(n, value);
            end
         end
         ACT_TAKE_FRONT, ACT_TAKE_BACK: begin
            if (n == 0) begin
               r.status = STS_UNDERFLOW;
            end else if (action == ACT_TAKE_FRONT) begin
               shadow_words.delete(0);
            end else begin
               shadow_words.delete(n - 1);
            end
         end
         ACT_CLEAR: begin
            shadow_words.delete();
         end
         ACT_REVERSE: begin
            for (i = 0; i < n / 2; i++) begin
               tmp = shadow_words[i];
               shadow_words[i] = shadow_words[n-1-i];
               shadow_words[n-1-i] = tmp;
            end
         end
         ACT_SORT: begin
            // ascending signed order; insertion sort is plenty for 64 words
            for (i = 1; i < n; i++) begin
               key = shadow_words[i];
               j = i - 1;
               while (j >= 0 && shadow_words[j] > key) begin
                  shadow_words[j+1] = shadow_words[j];
                  j--;
               end
               shadow_words[j+1] = key;
            end
         end
         default: begin
         end
      endcase
      n = shadow_words.size();
      r.is_empty    = (n == 0);
      r.is_full     = (n >= DEPTH);
      r.count       = n[COUNT_W-1:0];
      r.front_value = (n == 0) ? EMPTY_WORD : shadow_words[0];
      r.back_value  = (n == 0) ? EMPTY_WORD : shadow_words[n-1];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: offer one beat, hold it until accepted, then predict.
   // Returns at the falling edge after acceptance with tvalid still high,
   // so back-to-back calls keep the bus busy without a bubble.
   // ---------------------------------------------------------------------
   task automatic send_action(input logic [ACTION_W-1:0] action,
                              input logic signed [WORD_W-1:0] value);
      deque_rsp_type r;
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_DATA_W-WORD_W-ACTION_W){1'b0}}, value, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = apply_action(action, value);
      pending_rsp.insert(pending_rsp.size(), r);
      beats_sent++;
      if (r.status == STS_OVERFLOW) n_overflow++;
      if (r.status == STS_UNDERFLOW) n_underflow++;
      if (action == ACT_SORT && r.count > 1) n_sorts++;
      if (r.count > peak_count) peak_count = r.count;
      @(negedge clock);
   endtask

   // drop the request and wait for every outstanding response beat
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random tready, or a long hold-off when one is armed.
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready = 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic compare_field(input string name, input logic [WORD_W-1:0] want_v,
                                input logic [WORD_W-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected 0x%h, got 0x%h", name, want_v, got_v);
         err_count++;
      end
   endtask

   // scoreboard: every accepted response beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         if (pending_rsp.size() == 0) begin
            $error("response beat with nothing expected: 0x%h", rsp_tdata);
            err_count++;
         end else begin
            want_rsp = pending_rsp[0];
            pending_rsp.delete(0);
            got_rsp  = rsp_tdata[74:0];
            compare_field("status",      want_rsp.status,      got_rsp.status);
            compare_field("front_value", want_rsp.front_value, got_rsp.front_value);
            compare_field("back_value",  want_rsp.back_value,  got_rsp.back_value);
            compare_field("count",       want_rsp.count,       got_rsp.count);
            compare_field("is_empty",    want_rsp.is_empty,    got_rsp.is_empty);
            compare_field("is_full",     want_rsp.is_full,     got_rsp.is_full);
            compare_field("pad",         '0,                   rsp_tdata[RSP_DATA_W-1 -: PAD_W]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // every action but the pushes on an empty deque: pops underflow, the rest are no-ops
   task automatic test_empty_edges();
      send_action(ACT_TAKE_FRONT, $urandom);
      send_action(ACT_TAKE_BACK, $urandom);
      send_action(ACT_REVERSE, $urandom);
      send_action(ACT_SORT, $urandom);
      send_action(ACT_UNUSED, $urandom);
      send_action(ACT_CLEAR, $urandom);
   endtask

   // extreme words, duplicates, odd/even reverse, sort, single-word cases
   task automatic test_word_extremes();
      send_action(ACT_ADD_BACK, 32'sh7FFF_FFFF);
      send_action(ACT_ADD_FRONT, 32'sh8000_0000);
      send_action(ACT_ADD_BACK, -32'sd1);
      send_action(ACT_ADD_FRONT, 32'sd0);
      send_action(ACT_ADD_BACK, 32'sd1);
      send_action(ACT_ADD_FRONT, 32'sh8000_0000);
      send_action(ACT_REVERSE, $urandom);   // even count
      send_action(ACT_SORT, $urandom);
      send_action(ACT_TAKE_FRONT, $urandom);
      send_action(ACT_REVERSE, $urandom);   // odd count
      send_action(ACT_UNUSED, 32'shFFFF_FFFF);
      send_action(ACT_TAKE_BACK, $urandom);
      send_action(ACT_SORT, $urandom);
      send_action(ACT_CLEAR, $urandom);
      // one word: sort and reverse leave it alone, popping it empties
      send_action(ACT_ADD_FRONT, 32'sd42);
      send_action(ACT_SORT, $urandom);
      send_action(ACT_REVERSE, $urandom);
      send_action(ACT_TAKE_BACK, $urandom);
      // -1 stored looks like the empty marker; count and flag tell apart
      send_action(ACT_ADD_BACK, -32'sd1);
   endtask

   // fill to DEPTH, overflow both ends, sort and reverse a full ring, drain
   task automatic test_fill_and_overflow();
      int k;
      send_action(ACT_CLEAR, $urandom);
      for (k = 0; k < DEPTH; k++)
         send_action(k[0] ? ACT_ADD_FRONT : ACT_ADD_BACK, $urandom);
      send_action(ACT_ADD_FRONT, $urandom);
      send_action(ACT_ADD_BACK, $urandom);
      send_action(ACT_SORT, $urandom);
      send_action(ACT_REVERSE, $urandom);
      for (k = 0; k < DEPTH; k++)
         send_action(k[1] ? ACT_TAKE_FRONT : ACT_TAKE_BACK, $urandom);
      send_action(ACT_TAKE_FRONT, $urandom);
   endtask

   // receiver stalls for a long stretch while requests keep coming
   task automatic test_backpressure();
      int k;
      wait_drained();
      req_idle_pct  = 0;
      rsp_hold_left = 200;
      for (k = 0; k < 60; k++)
         send_action(($urandom_range(3) == 0) ? ACT_TAKE_BACK : ACT_ADD_FRONT, $urandom);
      // sender pauses until the queue of responses is empty
      wait_drained();
      send_action(ACT_SORT, $urandom);
      send_action(ACT_REVERSE, $urandom);
      send_action(ACT_TAKE_FRONT, $urandom);
   endtask

   // random actions; pushes and pops drift between filling and draining
   task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
      int k;
      int r;
      bit filling;
      bit push;
      logic [ACTION_W-1:0] act;
      logic signed [WORD_W-1:0] val;
      req_idle_pct = snd_pct;
      rsp_idle_pct = rcv_pct;
      filling = 1'b1;
      for (k = 0; k < n_items; k++) begin
         if (shadow_words.size() >= DEPTH) filling = 1'b0;
         else if (shadow_words.size() == 0) filling = 1'b1;
         else if ($urandom_range(99) < 2) filling = !filling;
         r = $urandom_range(99);
         if (r < 1) begin
            act = ACT_CLEAR;
         end else if (r < 5) begin
            act = ACT_REVERSE;
         end else if (r < 8) begin
            act = ACT_SORT;
         end else if (r < 9) begin
            act = ACT_UNUSED;
         end else begin
            push = ($urandom_range(99) < (filling ? 75 : 25));
            if (push) act = $urandom_range(1) ? ACT_ADD_FRONT : ACT_ADD_BACK;
            else act = $urandom_range(1) ? ACT_TAKE_FRONT : ACT_TAKE_BACK;
         end
         // small values give duplicates and sign changes for the sorter
         if ($urandom_range(3) == 0) val = $urandom_range(16) - 8;
         else val = $urandom;
         send_action(act, val);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;

      req_idle_pct = 6;
      rsp_idle_pct = 54;
      test_empty_edges();
      test_word_extremes();
      test_fill_and_overflow();
      test_backpressure();
      wait_drained();
      test_random_traffic(310, 6, 54);
      test_random_traffic(310, 54, 6);
      test_random_traffic(310, 0, 0);

      wait_drained();
      repeat (DEPTH + 20) @(negedge clock);

      $display("covered %0d request beats, %0d responses; %0d overflows, %0d underflows",
               beats_sent, beats_seen, n_overflow, n_underflow);
      $display("sorts of two or more words: %0d, peak occupancy %0d of %0d",
               n_sorts, peak_count, DEPTH);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
